[hdl/tks_pkg.sv]
// shared types, constants and helper functions of the table key search unit
// no dependencies; compiled first

package tks_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int POS_W       = 8;
	localparam int LEN_W       = 8;
	localparam int OP_W        = 2;
	localparam int DATA_W      = 32;

	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_LINEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_BINARY = 2'd2;

	typedef logic [OP_W-1:0]          op_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	// outcome of the shared key compare
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

	// table length in use, saturated at the last storable position
	function automatic cnt_t used_len(input len_t len);
		int n;
		n = int'(len);
		if (n > TABLE_DEPTH - 1) n = TABLE_DEPTH - 1;
		return cnt_t'(n);
	endfunction

	function automatic addr_t to_addr(input pos_t p);
		logic [31:0] w;
		w = 32'(p);
		return w[ADDR_W-1:0];
	endfunction

	function automatic pos_t to_pos(input cnt_t c);
		logic [31:0] w;
		w = 32'(c);
		return w[POS_W-1:0];
	endfunction

endpackage

[hdl/tks_if.sv]
// valid/ready channel interfaces: request, response and length register write
// depends on tks_pkg

interface tks_req_if;
	import tks_pkg::*;
	logic  valid;
	logic  ready;
	op_t   operation;
	pos_t  entry_position;
	data_t data_value;
	modport source (output valid, output operation, output entry_position,
		output data_value, input ready);
	modport sink (input valid, input operation, input entry_position,
		input data_value, output ready);
endinterface

interface tks_rsp_if;
	import tks_pkg::*;
	logic valid;
	logic ready;
	logic found;
	pos_t position;
	modport source (output valid, output found, output position, input ready);
	modport sink (input valid, input found, input position, output ready);
endinterface

interface tks_cfg_if;
	import tks_pkg::*;
	logic valid;
	logic ready;
	len_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/tks_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies

module tks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/tks_cmp.sv]
// shared signed 32-bit key compare used by both search modes
// depends on tks_pkg

module tks_cmp (
	input  tks_pkg::data_t    key,
	input  tks_pkg::data_t    entry,
	output tks_pkg::cmp_res_t res
);
	import tks_pkg::*;

	assign res.lt = key < entry;
	assign res.eq = key == entry;

endmodule

[hdl/table_key_search_unit.sv]
// table key search unit: top level with sequencer, table ram and shared compare
// depends on tks_pkg, tks_if, tks_ram, tks_cmp
//
// usage
//  - cfg channel: one transfer writes table_length (positions 1..length in use);
//    always ready, write it only while the unit is idle
//  - req channel: operation write / linear / binary, entry_position, data_value;
//    ready only while the sequencer is idle, one item at a time
//  - rsp channel: one transfer per request, found and position (0 when missing)
//  - write: stored on the request transfer (position 0 and out-of-range ignored),
//    answered found 0 through the done state
//  - linear search: one table read per cycle from the top down through the ram
//    read port, pipelined against the compare
//  - binary search: each probe passes a ram read state, then a compare state
//  - the next request is taken while a finished result still waits in the
//    response register; a stalled receiver holds the response and, behind it,
//    at most one more finished result
//  - reset clears the length register and the control state; table contents
//    are undefined until written, no clearing pass

module table_key_search_unit (
	input logic          clk,
	input logic          arst_n,
	tks_req_if.sink      req,
	tks_rsp_if.source    rsp,
	tks_cfg_if.sink      cfg
);
	import tks_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LIN  = 3'd1;
	localparam logic [2:0] ST_BRD  = 3'd2;
	localparam logic [2:0] ST_BCMP = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	len_t       len_q;
	data_t      key_q;
	cnt_t       idx_q;      // next linear position to read
	cnt_t       pos_s1;     // linear position whose data arrives now, 0 for none
	cnt_t       left_q;
	cnt_t       right_q;
	cnt_t       mid_q;
	logic       res_found_q;
	cnt_t       res_pos_q;
	logic       rsp_valid_q;
	logic       rsp_found_q;
	cnt_t       rsp_pos_q;

	logic       req_xfer;
	logic       ram_we;
	addr_t      rd_addr;
	data_t      rd_data;
	logic [CNT_W:0] mid_sum;
	cnt_t       mid_next;
	cmp_res_t   cmp;
	logic       out_free;

	assign req.ready = state_q == ST_IDLE;
	assign req_xfer  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = rsp_found_q;
	assign rsp.position = to_pos(rsp_pos_q);

	// response register can take a new result
	assign out_free = !rsp_valid_q || rsp.ready;

	// table write goes straight to the ram on the request transfer
	assign ram_we = req_xfer && req.operation == OP_WRITE && req.entry_position != '0
		&& int'(req.entry_position) < TABLE_DEPTH;

	// midpoint of the current binary search window
	assign mid_sum  = {1'b0, left_q} + {1'b0, right_q};
	assign mid_next = mid_sum[CNT_W:1];

	assign rd_addr = (state_q == ST_BRD) ? mid_next[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	tks_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(to_addr(req.entry_position)),
		.wdata(req.data_value),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	tks_cmp u_cmp (
		.key  (key_q),
		.entry(rd_data),
		.res  (cmp)
	);

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			len_q <= cfg.data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_s1      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						key_q       <= req.data_value;
						res_found_q <= 1'b0;
						res_pos_q   <= '0;
						priority if (req.operation == OP_LINEAR) begin
							idx_q   <= used_len(len_q);
							pos_s1  <= '0;
							state_q <= ST_LIN;
						end else if (req.operation == OP_BINARY) begin
							left_q  <= cnt_t'(1);
							right_q <= used_len(len_q);
							state_q <= ST_BRD;
						end else begin
							// write or unused code: plain acknowledge
							state_q <= ST_DONE;
						end
					end
				end

				ST_LIN: begin
					priority if (pos_s1 != '0 && cmp.eq) begin
						// highest matching position
						res_found_q <= 1'b1;
						res_pos_q   <= pos_s1;
						state_q     <= ST_DONE;
					end else if (pos_s1 == '0 && idx_q == '0) begin
						// reached the sentinel slot
						state_q <= ST_DONE;
					end else begin
						pos_s1 <= idx_q;
						if (idx_q != '0) idx_q <= idx_q - cnt_t'(1);
					end
				end

				ST_BRD: begin
					if (left_q <= right_q) begin
						mid_q   <= mid_next;
						state_q <= ST_BCMP;
					end else begin
						state_q <= ST_DONE;
					end
				end

				ST_BCMP: begin
					priority if (cmp.eq) begin
						res_found_q <= 1'b1;
						res_pos_q   <= mid_q;
						state_q     <= ST_DONE;
					end else if (cmp.lt) begin
						right_q <= mid_q - cnt_t'(1);
						state_q <= ST_BRD;
					end else begin
						left_q  <= mid_q + cnt_t'(1);
						state_q <= ST_BRD;
					end
				end

				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// response valid: set by a finished result, cleared by the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload, loaded with the finished result
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_found_q <= res_found_q;
			rsp_pos_q   <= res_pos_q;
		end
	end

	// the table is only written while the sequencer is idle
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_IDLE)
		else $error("table write outside idle");

	// the linear data in flight belongs to the position just above the next read
	a_lin_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIN && pos_s1 != '0) |-> pos_s1 == idx_q + cnt_t'(1))
		else $error("linear read pipeline out of step");

	// a binary probe stays inside its window and never hits the sentinel
	a_bin_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BCMP |-> (mid_q >= left_q && mid_q <= right_q && mid_q != '0))
		else $error("binary probe outside window");

	// a found result always carries a position and a miss never does
	a_rsp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.found == (rsp.position != '0))
		else $error("found flag and position disagree");

endmodule

[tb/testbench.sv]
// self-checking testbench for table_key_search_unit: writes, linear and binary searches
// depends on tks_pkg and the channel interfaces in tks_if; drives all channels and checks the responses
`timescale 1ns / 100ps

module testbench;
	import tks_pkg::*;

	// the one operation code the unit does not define
	localparam op_t OP_UNUSED = 2'd3;

	typedef struct {
		op_t   op;
		pos_t  slot;
		data_t key;
	} job_t;

	typedef struct {
		logic found;
		pos_t position;
	} answer_t;

	logic clk;
	logic arst_n;

	tks_req_if req ();
	tks_rsp_if rsp ();
	tks_cfg_if cfg ();

	table_key_search_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// predictor state: the table as the unit should hold it, and the length in use
	data_t   model_entries [TABLE_DEPTH];
	len_t    model_len;

	// stimulus side bookkeeping: what has been queued so far, in queue order
	data_t   shadow [TABLE_DEPTH];
	bit      filled [TABLE_DEPTH];
	int      made_items;

	job_t    job_backlog [$];
	answer_t pending_answers [$];
	job_t    on_bus;
	answer_t want;

	int      req_count;
	int      hold_left;
	int      next_hold_at;
	int      errors;
	int      n_write, n_linear, n_binary, n_other, n_found, n_resp;

	// clock and the single reset
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_WRITE;
		req.entry_position = '0;
		req.data_value = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// idle percentages: sender rarely and receiver mostly idle first, then swapped,
	// then back to back on both sides
	function automatic int idle_pct(input bit sender);
		if (req_count < 470) return sender ? 9 : 83;
		if (req_count < 940) return sender ? 83 : 9;
		return 0;
	endfunction

	// predictor: applies one request to the model table and returns the answer
	function automatic answer_t search_or_store(input job_t j);
		answer_t a;
		int      n, hit, lo, hi, mid;
		n = int'(model_len);
		if (n > TABLE_DEPTH - 1) n = TABLE_DEPTH - 1;
		hit = 0;
		case (j.op)
			OP_WRITE: begin
				// the sentinel slot is never stored
				if (j.slot != 0 && int'(j.slot) < TABLE_DEPTH) model_entries[j.slot] = j.key;
			end
			OP_LINEAR: begin
				// top down, so the highest matching position wins
				hit = n;
				while (hit != 0 && model_entries[hit] != j.key) hit--;
			end
			OP_BINARY: begin
				// first probe that matches is reported, sorted or not
				lo = 1;
				hi = n;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (j.key < model_entries[mid]) hi = mid - 1;
					else if (j.key > model_entries[mid]) lo = mid + 1;
					else begin
						hit = mid;
						lo = hi + 1;
					end
				end
			end
			default: begin
				// unknown operation leaves the table alone
			end
		endcase
		a.found = (hit != 0);
		a.position = pos_t'(hit);
		return a;
	endfunction

	// request driver: on each transfer the predictor runs and the answer is queued,
	// then the next job from the backlog is offered unless the sender idles
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				pending_answers.push_back(search_or_store(on_bus));
				req_count <= req_count + 1;
				case (on_bus.op)
					OP_WRITE:  n_write++;
					OP_LINEAR: n_linear++;
					OP_BINARY: n_binary++;
					default:   n_other++;
				endcase
			end
			if (!req.valid || req.ready) begin
				if (job_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					on_bus = job_backlog.pop_front();
					req.valid <= 1'b1;
					req.operation <= on_bus.op;
					req.entry_position <= on_bus.slot;
					req.data_value <= on_bus.key;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-offs: the sender keeps offering, so the unit fills its
	// response slots and has to drop req.ready
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			next_hold_at <= 300;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (req_count >= next_hold_at) begin
			hold_left <= 400;
			next_hold_at <= next_hold_at + 700;
		end
	end

	// response monitor: every transfer is checked against the oldest answer
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				n_resp++;
				if (rsp.found === 1'b1) n_found++;
				if (pending_answers.size() == 0) begin
					errors++;
					$display("%0t: response with nothing expected: found=%0b position=%0d",
						$time, rsp.found, rsp.position);
				end else begin
					want = pending_answers.pop_front();
					if (rsp.found !== want.found || rsp.position !== want.position) begin
						errors++;
						$display("%0t: expected found=%0b position=%0d, got found=%0b position=%0d",
							$time, want.found, want.position, rsp.found, rsp.position);
					end
				end
			end
			rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	task automatic push_job(input op_t op, input pos_t slot, input data_t key);
		job_t j;
		j.op = op;
		j.slot = slot;
		j.key = key;
		job_backlog.push_back(j);
		if (op == OP_WRITE && slot != 0) begin
			shadow[slot] = key;
			filled[slot] = 1'b1;
		end
		if (op != OP_UNUSED && !(op == OP_WRITE && slot == 0)) made_items++;
	endtask

	// nothing queued, nothing on the bus, every answer back
	task automatic wait_idle();
		do @(negedge clk);
		while (job_backlog.size() != 0 || req.valid || pending_answers.size() != 0);
	endtask

	// length register write, only while the unit is idle
	task automatic set_length(input len_t len);
		wait_idle();
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= len;
		do @(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		model_len = len;
	endtask

	// ascending fill of positions 1..n, small steps give duplicate runs,
	// the top clamps at the largest value
	task automatic fill_sorted(input int n);
		longint v;
		int     p;
		if ($urandom_range(3) == 0) v = longint'(data_t'(32'h8000_0000));
		else v = longint'($signed($urandom));
		for (p = 1; p <= n; p++) begin
			push_job(OP_WRITE, pos_t'(p), data_t'(v));
			if ($urandom_range(3) == 0) v += $urandom_range(2);
			else v += $urandom_range(1 << 24);
			if (v > 2147483647) v = 2147483647;
		end
	endtask

	// unsorted fill: every used position written at least once, some from a
	// tiny value pool so that duplicates show up
	task automatic fill_random(input int n);
		int    p;
		data_t v;
		for (p = 1; p <= n; p++) begin
			if (!filled[p] || $urandom_range(3) == 0) begin
				if ($urandom_range(1) == 0) v = data_t'($urandom_range(7));
				else v = data_t'($urandom);
				push_job(OP_WRITE, pos_t'(p), v);
			end
		end
	endtask

	// search key: mostly a stored entry, some neighbors of one, some anything
	function automatic data_t pick_key(input int n);
		int    r;
		data_t k;
		r = $urandom_range(99);
		if (n == 0 || r >= 85) return data_t'($urandom);
		k = shadow[$urandom_range(n, 1)];
		if (r >= 70) k = ($urandom_range(1) == 0) ? k + 1 : k - 1;
		return k;
	endfunction

	// searches with writes and the odd ignored item in between; in a sorted table
	// writes inside the used range store the value already there
	task automatic mixed_traffic(input int count, input int n, input bit sorted);
		int    i, r, slot;
		data_t v;
		for (i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				push_job(OP_LINEAR, pos_t'($urandom), pick_key(n));
			end else if (r < 80) begin
				push_job(OP_BINARY, pos_t'($urandom), pick_key(n));
			end else if (r < 94) begin
				slot = $urandom_range(255);
				v = data_t'($urandom);
				if (sorted && slot >= 1 && slot <= n) v = shadow[slot];
				push_job(OP_WRITE, pos_t'(slot), v);
			end else if (r < 97) begin
				push_job(OP_WRITE, pos_t'(0), data_t'($urandom));
			end else begin
				push_job(OP_UNUSED, pos_t'($urandom), data_t'($urandom));
			end
		end
	endtask

	// stimulus: directed corners, then phases of length setting, fill and traffic
	initial begin
		int phase, n;
		bit sorted;
		made_items = 0;
		errors = 0;
		req_count = 0;
		n_write = 0;
		n_linear = 0;
		n_binary = 0;
		n_other = 0;
		n_found = 0;
		n_resp = 0;
		model_len = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			model_entries[i] = '0;
			shadow[i] = '0;
			filled[i] = 1'b0;
		end

		// zero length after reset: both searches miss without reading the table
		push_job(OP_LINEAR, pos_t'(8'hff), data_t'(32'h0));
		push_job(OP_BINARY, pos_t'(8'h00), data_t'(32'h7fff_ffff));
		push_job(OP_UNUSED, pos_t'(8'haa), data_t'(32'h5555_5555));
		// sentinel write is dropped, top position is stored
		push_job(OP_WRITE, pos_t'(8'h00), data_t'(32'ha5a5_a5a5));
		push_job(OP_WRITE, pos_t'(8'hff), data_t'(32'h1234_5678));
		// small sorted table with both extremes of the key range
		push_job(OP_WRITE, pos_t'(1), data_t'(32'h8000_0000));
		push_job(OP_WRITE, pos_t'(2), data_t'(32'hffff_ffff));
		push_job(OP_WRITE, pos_t'(3), data_t'(32'h0000_0000));
		push_job(OP_WRITE, pos_t'(4), data_t'(32'h7fff_ffff));
		set_length(len_t'(4));
		push_job(OP_LINEAR, pos_t'(8'h55), data_t'(32'h8000_0000));
		push_job(OP_LINEAR, pos_t'(8'haa), data_t'(32'h7fff_ffff));
		push_job(OP_LINEAR, pos_t'(8'h01), data_t'(32'h0000_0000));
		push_job(OP_LINEAR, pos_t'(8'h80), data_t'(32'hffff_ffff));
		push_job(OP_LINEAR, pos_t'(8'h7f), data_t'(32'h0000_0005));
		push_job(OP_BINARY, pos_t'(8'hfe), data_t'(32'h8000_0000));
		push_job(OP_BINARY, pos_t'(8'h01), data_t'(32'h7fff_ffff));
		push_job(OP_BINARY, pos_t'(8'h33), data_t'(32'hffff_ffff));
		push_job(OP_BINARY, pos_t'(8'hcc), data_t'(32'h0000_0000));
		push_job(OP_BINARY, pos_t'(8'h0f), data_t'(32'h0000_0005));
		// duplicate key: linear reports the higher copy, binary its first probe
		push_job(OP_WRITE, pos_t'(3), data_t'(32'hffff_ffff));
		push_job(OP_LINEAR, pos_t'(8'hf0), data_t'(32'hffff_ffff));
		push_job(OP_BINARY, pos_t'(8'h0f), data_t'(32'hffff_ffff));

		// random phases; the first two force the longest and the empty table
		phase = 0;
		while (made_items < 1400) begin
			case (phase)
				0: n = 255;
				1: n = 0;
				default: begin
					case ($urandom_range(9))
						0: n = 0;
						1: n = 1;
						2: n = 2;
						3: n = 255;
						4, 5: n = $urandom_range(40, 3);
						default: n = $urandom_range(12, 3);
					endcase
				end
			endcase
			sorted = ($urandom_range(9) < 7);
			set_length(len_t'(n));
			if (sorted) fill_sorted(n);
			else fill_random(n);
			mixed_traffic((n == 255) ? 16 : $urandom_range(60, 20), n, sorted);
			phase++;
		end

		// drain, then let any stray response show itself
		wait_idle();
		repeat (300) @(posedge clk);
		if (pending_answers.size() != 0) errors++;
		$display("covered %0d phases: %0d writes, %0d linear, %0d binary, %0d unknown ops",
			phase, n_write, n_linear, n_binary, n_other);
		$display("%0d responses checked, %0d of them hits, %0d errors", n_resp, n_found, errors);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
hdl/tks_pkg.sv
hdl/tks_if.sv
hdl/tks_ram.sv
hdl/tks_cmp.sv
hdl/table_key_search_unit.sv
tb/testbench.sv
